FILE: rtl/sqd_pkg.sv
// shared types and constants of the shortest-queue dispatcher
// used by the controller, datapath, top level and testbench; depends on nothing
package sqd_pkg;

  localparam int unsigned UNIT_W = 3;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned SVC_W  = 10;
  localparam int unsigned TIME_W = 16;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef enum logic [2:0] {
    KIND_ENQUEUED = 3'd0,
    KIND_REJECTED = 3'd1,
    KIND_STARTED  = 3'd2,
    KIND_IDLE     = 3'd3,
    KIND_BUSY     = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ARRIVE,
    ST_TICK
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic              cap;      // request accepted, snapshot fields
    logic              arrive;   // place the arrival, emit its result
    logic              serve;    // serve server 'unit', emit its result
    logic              last;     // emitted result closes the request
    logic              adv;      // advance the time
    logic              rd_en;    // read head entry of queue 'rd_unit'
    logic [UNIT_W-1:0] unit;
    logic [UNIT_W-1:0] rd_unit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/sqd_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module sqd_ram #(
  parameter int unsigned WIDTH = 26,
  parameter int unsigned DEPTH = 192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/sqd_datapath.sv
// datapath: queue pointers, server state, time, queue ram and result register
// depends on sqd_pkg and sqd_ram
module sqd_datapath #(
  parameter int unsigned NUM_QUEUES  = 3,
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sqd_pkg::cmd_t                 cmd_i,
  output sqd_pkg::sts_t                 sts_o,
  input  logic [sqd_pkg::ID_W-1:0]      customer_id_i,
  input  logic [sqd_pkg::SVC_W-1:0]     service_time_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sqd_pkg::kind_e                kind_o,
  output logic [sqd_pkg::UNIT_W-1:0]    unit_index_o,
  output logic [sqd_pkg::ID_W-1:0]      job_id_o,
  output logic [sqd_pkg::TIME_W-1:0]    finish_time_o,
  output logic [sqd_pkg::TIME_W-1:0]    time_now_o,
  output logic                          all_idle_o,
  output logic                          last_o
);
  import sqd_pkg::*;

  localparam int unsigned QW     = $clog2(NUM_QUEUES);
  localparam int unsigned PW     = $clog2(QUEUE_DEPTH);
  localparam int unsigned FW     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SLOTS  = NUM_QUEUES * QUEUE_DEPTH;
  localparam int unsigned AW     = $clog2(SLOTS);
  localparam int unsigned ENT_W  = ID_W + SVC_W;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PW'(1);
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] slot_addr(input logic [QW-1:0] q, input logic [PW-1:0] p);
    return AW'(q) * AW'(QUEUE_DEPTH) + AW'(p);
  endfunction

  logic [FW-1:0]     fill_q [NUM_QUEUES];
  logic [PW-1:0]     head_q [NUM_QUEUES];
  logic [PW-1:0]     tail_q [NUM_QUEUES];
  logic              busy_q [NUM_QUEUES];
  logic [TIME_W-1:0] end_q  [NUM_QUEUES];
  logic [ID_W-1:0]   job_q  [NUM_QUEUES];
  logic [TIME_W-1:0] time_q;

  logic [ID_W-1:0]   cid_q;
  logic [SVC_W-1:0]  svc_q;
  logic              tick_idle_q;

  logic              out_valid_q;
  kind_e             out_kind_q;
  logic [UNIT_W-1:0] out_unit_q;
  logic [ID_W-1:0]   out_job_q;
  logic [TIME_W-1:0] out_fin_q;
  logic [TIME_W-1:0] out_now_q;
  logic              out_idle_q;
  logic              out_last_q;

  // arrival: pick the shortest queue, lower index wins ties
  logic [QW-1:0]     best;
  logic [FW:0]       best_len;
  logic              full;

  always_comb begin
    logic [FW:0] len;
    best     = '0;
    best_len = {1'b0, fill_q[0]} + (FW+1)'(busy_q[0]);
    for (int i = 1; i < NUM_QUEUES; i++) begin
      len = {1'b0, fill_q[i]} + (FW+1)'(busy_q[i]);
      if (len < best_len) begin
        best_len = len;
        best     = QW'(i);
      end
    end
  end

  assign full = (fill_q[best] == FW'(QUEUE_DEPTH));

  // the state after a whole tick is idle when each server is either
  // expiring or free and its queue is empty
  logic idle_pred;

  always_comb begin
    idle_pred = 1'b1;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      if ((busy_q[i] && (end_q[i] > time_q)) || (fill_q[i] != '0)) begin
        idle_pred = 1'b0;
      end
    end
  end

  // queue ram
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [ENT_W-1:0]  ram_rdata;
  logic [QW-1:0]     rd_q_idx;

  assign ram_we    = cmd_i.arrive && !full;
  assign ram_waddr = slot_addr(best, tail_q[best]);
  assign rd_q_idx  = cmd_i.rd_unit[QW-1:0];
  assign ram_raddr = slot_addr(rd_q_idx, head_q[rd_q_idx]);

  sqd_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOTS)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({cid_q, svc_q}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // serving one server
  logic [QW-1:0]     u;
  logic              srv_free;
  logic              srv_start;
  logic [TIME_W:0]   end_sum;
  logic [TIME_W-1:0] end_new;
  logic [ID_W-1:0]   head_id;
  logic [SVC_W-1:0]  head_svc;

  assign u         = cmd_i.unit[QW-1:0];
  assign head_id   = ram_rdata[ENT_W-1:SVC_W];
  assign head_svc  = ram_rdata[SVC_W-1:0];
  assign srv_free  = !busy_q[u] || (end_q[u] <= time_q);
  assign srv_start = srv_free && (fill_q[u] != '0);
  assign end_sum   = {1'b0, time_q} + (TIME_W+1)'(head_svc);
  assign end_new   = end_sum[TIME_W] ? TIME_MAX : end_sum[TIME_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        fill_q[i] <= '0;
        head_q[i] <= '0;
        tail_q[i] <= '0;
        busy_q[i] <= 1'b0;
        end_q[i]  <= '0;
        job_q[i]  <= '0;
      end
      time_q <= '0;
    end else begin
      if (ram_we) begin
        tail_q[best] <= ptr_inc(tail_q[best]);
        fill_q[best] <= fill_q[best] + FW'(1);
      end
      if (cmd_i.serve) begin
        if (srv_start) begin
          head_q[u] <= ptr_inc(head_q[u]);
          fill_q[u] <= fill_q[u] - FW'(1);
          busy_q[u] <= 1'b1;
          end_q[u]  <= end_new;
          job_q[u]  <= head_id;
        end else if (srv_free) begin
          busy_q[u] <= 1'b0;
        end
      end
      if (cmd_i.adv && (time_q != TIME_MAX)) begin
        time_q <= time_q + TIME_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      cid_q       <= customer_id_i;
      svc_q       <= service_time_i;
      tick_idle_q <= idle_pred;
    end
  end

  // result register
  logic out_load;

  assign out_load       = cmd_i.arrive || cmd_i.serve;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.arrive) begin
      out_kind_q <= full ? KIND_REJECTED : KIND_ENQUEUED;
      out_unit_q <= UNIT_W'(best);
      out_job_q  <= cid_q;
      out_fin_q  <= '0;
      out_now_q  <= time_q;
      // any arrival leaves its chosen queue non-empty
      out_idle_q <= 1'b0;
      out_last_q <= 1'b1;
    end else if (cmd_i.serve) begin
      out_unit_q <= cmd_i.unit;
      out_now_q  <= time_q;
      out_idle_q <= tick_idle_q;
      out_last_q <= cmd_i.last;
      if (srv_start) begin
        out_kind_q <= KIND_STARTED;
        out_job_q  <= head_id;
        out_fin_q  <= end_new;
      end else if (srv_free) begin
        out_kind_q <= KIND_IDLE;
        out_job_q  <= '0;
        out_fin_q  <= '0;
      end else begin
        out_kind_q <= KIND_BUSY;
        out_job_q  <= job_q[u];
        out_fin_q  <= end_q[u];
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_kind_q;
  assign unit_index_o  = out_unit_q;
  assign job_id_o      = out_job_q;
  assign finish_time_o = out_fin_q;
  assign time_now_o    = out_now_q;
  assign all_idle_o    = out_idle_q;
  assign last_o        = out_last_q;

endmodule

FILE: rtl/sqd_ctrl.sv
// controller: sequences arrivals and the per-server walk of a tick
// depends on sqd_pkg
module sqd_ctrl #(
  parameter int unsigned NUM_QUEUES = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          action_i,
  input  sqd_pkg::sts_t sts_i,
  output sqd_pkg::cmd_t cmd_o
);
  import sqd_pkg::*;

  localparam logic [UNIT_W-1:0] LAST_UNIT = UNIT_W'(NUM_QUEUES - 1);

  state_e            state_q, state_d;
  logic [UNIT_W-1:0] unit_q, unit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      unit_q  <= '0;
    end else begin
      state_q <= state_d;
      unit_q  <= unit_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    unit_d     = unit_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.unit = unit_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          unit_d    = '0;
          if (action_i) begin
            // fetch the head of queue 0 ahead of serving server 0
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_unit = '0;
            state_d       = ST_TICK;
          end else begin
            state_d = ST_ARRIVE;
          end
        end
      end
      ST_ARRIVE: begin
        if (sts_i.out_free) begin
          cmd_o.arrive = 1'b1;
          cmd_o.last   = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_TICK: begin
        if (sts_i.out_free) begin
          cmd_o.serve = 1'b1;
          if (unit_q == LAST_UNIT) begin
            cmd_o.last = 1'b1;
            cmd_o.adv  = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_unit = unit_q + UNIT_W'(1);
            unit_d        = unit_q + UNIT_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.arrive || cmd_o.serve) |-> sts_i.out_free)
    else $error("result issued while result register occupied");

  a_adv_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.adv |-> (cmd_o.serve && cmd_o.last && (cmd_o.unit == LAST_UNIT)))
    else $error("time advanced outside last server");

  a_serve_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |=> (state_q == ST_TICK) && (unit_q == $past(cmd_o.rd_unit)))
    else $error("head read not followed by serve of the same server");

  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.arrive && cmd_o.serve) && !(cmd_o.cap && (cmd_o.arrive || cmd_o.serve)))
    else $error("conflicting datapath commands");
`endif

endmodule

FILE: rtl/shortest_queue_dispatch_servers.sv
// channel  | handshake                  | payload
// request  | in_valid_i / in_ready_o    | action_i, customer_id_i, service_time_i
// result   | out_valid_o / out_ready_i  | kind_o, unit_index_o, job_id_o, finish_time_o,
//          |                            | time_now_o, all_idle_o, last_o
//
// an arrival is accepted, then the shortest queue is picked and the queue ram written
// a tick is accepted with a head read of queue 0, then serves one
// server per cycle while the next queue head is read from the single queue ram
// a full result register stalls the walk; a new request is taken once the
// previous one has issued its last result, while that result may still wait
// reset clears pointers, fill counts, servers and time; queue ram is not cleared
// depends on sqd_pkg, sqd_ctrl, sqd_datapath
module shortest_queue_dispatch_servers #(
  parameter int unsigned NUM_QUEUES  = 3,
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic [sqd_pkg::ID_W-1:0]      customer_id_i,
  input  logic [sqd_pkg::SVC_W-1:0]     service_time_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    kind_o,
  output logic [sqd_pkg::UNIT_W-1:0]    unit_index_o,
  output logic [sqd_pkg::ID_W-1:0]      job_id_o,
  output logic [sqd_pkg::TIME_W-1:0]    finish_time_o,
  output logic [sqd_pkg::TIME_W-1:0]    time_now_o,
  output logic                          all_idle_o,
  output logic                          last_o
);
  import sqd_pkg::*;

  cmd_t  cmd;
  sts_t  sts;
  kind_e kind;

  sqd_ctrl #(
    .NUM_QUEUES (NUM_QUEUES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sqd_datapath #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .customer_id_i  (customer_id_i),
    .service_time_i (service_time_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind),
    .unit_index_o   (unit_index_o),
    .job_id_o       (job_id_o),
    .finish_time_o  (finish_time_o),
    .time_now_o     (time_now_o),
    .all_idle_o     (all_idle_o),
    .last_o         (last_o)
  );

  assign kind_o = kind;

endmodule

FILE: verif/tb_shortest_queue_dispatch_servers.sv
// self-checking testbench for the shortest-queue dispatcher: directed and random requests,
// a predictor of queues, servers and time, and in-order checking of every result
// depends on sqd_pkg and shortest_queue_dispatch_servers
module tb_shortest_queue_dispatch_servers;
  import sqd_pkg::*;

  localparam int NQ = 3;
  localparam int QD = 64;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic              act;
    logic [ID_W-1:0]   id;
    logic [SVC_W-1:0]  svc;
  } req_t;

  typedef struct {
    kind_e             kind;
    logic [UNIT_W-1:0] unit;
    logic [ID_W-1:0]   job;
    logic [TIME_W-1:0] fin;
    logic [TIME_W-1:0] now;
    logic              all_idle;
    logic              last;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             in_valid = 1'b0;
  logic             in_action = 1'b0;
  logic [ID_W-1:0]  in_id = '0;
  logic [SVC_W-1:0] in_svc = '0;
  logic             out_ready = 1'b0;

  logic              in_ready;
  logic              out_valid;
  logic [2:0]        out_kind;
  logic [UNIT_W-1:0] out_unit;
  logic [ID_W-1:0]   out_job;
  logic [TIME_W-1:0] out_fin;
  logic [TIME_W-1:0] out_now;
  logic              out_all_idle;
  logic              out_last;

  shortest_queue_dispatch_servers #(
    .NUM_QUEUES  (NQ),
    .QUEUE_DEPTH (QD)
  ) uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .action_i       (in_action),
    .customer_id_i  (in_id),
    .service_time_i (in_svc),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .kind_o         (out_kind),
    .unit_index_o   (out_unit),
    .job_id_o       (out_job),
    .finish_time_o  (out_fin),
    .time_now_o     (out_now),
    .all_idle_o     (out_all_idle),
    .last_o         (out_last)
  );

  // dispatcher state as predicted
  logic [ID_W-1:0]   qs_id  [NQ][QD];
  logic [SVC_W-1:0]  qs_svc [NQ][QD];
  int unsigned       q_head [NQ] = '{default: 0};
  int unsigned       q_tail [NQ] = '{default: 0};
  int unsigned       q_fill [NQ] = '{default: 0};
  logic              srv_busy [NQ] = '{default: 1'b0};
  logic [TIME_W-1:0] srv_end  [NQ] = '{default: '0};
  logic [ID_W-1:0]   srv_job  [NQ] = '{default: '0};
  logic [TIME_W-1:0] clock_now = '0;

  result_t     pending_results[$];
  req_t        pend_reqs[$];
  req_t        next_req;
  result_t     oldest;
  int unsigned reqs_pushed = 0;
  int unsigned reqs_taken_cnt = 0;
  int unsigned errors = 0;
  logic        req_taken = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_go = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_cnt = 0;

  function automatic void dispatch_predict(input logic act, input logic [ID_W-1:0] id,
                                           input logic [SVC_W-1:0] svc);
    result_t     batch[$];
    result_t     r;
    int          best;
    int unsigned len;
    int unsigned best_len;
    logic [TIME_W:0] sum;
    logic        idle;
    r.now = clock_now;
    r.all_idle = 1'b0;
    r.last = 1'b0;
    if (act == 1'b0) begin
      best = 0;
      best_len = q_fill[0] + (srv_busy[0] ? 1 : 0);
      for (int i = 1; i < NQ; i++) begin
        len = q_fill[i] + (srv_busy[i] ? 1 : 0);
        if (len < best_len) begin
          best_len = len;
          best = i;
        end
      end
      r.unit = UNIT_W'(best);
      r.job = id;
      r.fin = '0;
      if (q_fill[best] >= QD) begin
        r.kind = KIND_REJECTED;
      end else begin
        qs_id[best][q_tail[best]] = id;
        qs_svc[best][q_tail[best]] = svc;
        q_tail[best] = (q_tail[best] + 1) % QD;
        q_fill[best]++;
        r.kind = KIND_ENQUEUED;
      end
      batch.push_back(r);
    end else begin
      for (int i = 0; i < NQ; i++) begin
        if (srv_end[i] <= clock_now) srv_busy[i] = 1'b0;
        r.unit = UNIT_W'(i);
        if (!srv_busy[i]) begin
          if (q_fill[i] > 0) begin
            sum = {1'b0, clock_now} + (TIME_W+1)'(qs_svc[i][q_head[i]]);
            srv_end[i] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
            srv_job[i] = qs_id[i][q_head[i]];
            srv_busy[i] = 1'b1;
            q_head[i] = (q_head[i] + 1) % QD;
            q_fill[i]--;
            r.kind = KIND_STARTED;
            r.job = srv_job[i];
            r.fin = srv_end[i];
          end else begin
            r.kind = KIND_IDLE;
            r.job = '0;
            r.fin = '0;
          end
        end else begin
          r.kind = KIND_BUSY;
          r.job = srv_job[i];
          r.fin = srv_end[i];
        end
        batch.push_back(r);
      end
      if (clock_now != TIME_MAX) clock_now++;
    end
    idle = 1'b1;
    for (int i = 0; i < NQ; i++)
      if (srv_busy[i] || q_fill[i] != 0) idle = 1'b0;
    for (int k = 0; k < batch.size(); k++) begin
      r = batch[k];
      r.all_idle = idle;
      r.last = (k == batch.size() - 1);
      pending_results.push_back(r);
    end
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic push_req(input logic act, input logic [ID_W-1:0] id,
                          input logic [SVC_W-1:0] svc);
    req_t q;
    q.act = act;
    q.id = id;
    q.svc = svc;
    pend_reqs.push_back(q);
    reqs_pushed++;
  endtask

  // mostly short jobs so servers keep turning over; ticks carry random ignored fields
  task automatic add_mix(input int n);
    logic [SVC_W-1:0] svc;
    for (int i = 0; i < n; i++) begin
      svc = ($urandom_range(99) < 95) ? SVC_W'($urandom_range(7)) : SVC_W'($urandom);
      if ($urandom_range(99) < 60) push_req(1'b1, ID_W'($urandom), SVC_W'($urandom));
      else push_req(1'b0, ID_W'($urandom), svc);
    end
  endtask

  task automatic push_ticks(input int n);
    for (int i = 0; i < n; i++) push_req(1'b1, ID_W'($urandom), SVC_W'($urandom));
  endtask

  // every request taken and every result out; sampled away from the active edge
  task automatic wait_drain;
    do @(negedge clk);
    while (reqs_taken_cnt != reqs_pushed || pending_results.size() != 0);
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !req_taken) begin
      in_valid <= 1'b1;
    end else if (pend_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      next_req = pend_reqs.pop_front();
      in_valid <= 1'b1;
      in_action <= next_req.act;
      in_id <= next_req.id;
      in_svc <= next_req.svc;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result receiver, with one long hold-off to back the block up
  always @(negedge clk) begin
    if (hold_go && !hold_done) begin
      hold_cnt++;
      if (hold_cnt >= HOLD_CYCLES) hold_done = 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // accept, predict and check
  always @(posedge clk) begin
    if (!rst_n) begin
      req_taken = 1'b0;
    end else begin
      req_taken = in_valid && in_ready;
      if (req_taken) begin
        dispatch_predict(in_action, in_id, in_svc);
        reqs_taken_cnt++;
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual kind %0d unit %0d job %0h",
                   $time, out_kind, out_unit, out_job);
          errors++;
        end else begin
          oldest = pending_results.pop_front();
          check_field("kind", 16'(oldest.kind), 16'(out_kind));
          check_field("unit_index", 16'(oldest.unit), 16'(out_unit));
          check_field("job_id", oldest.job, out_job);
          check_field("finish_time", oldest.fin, out_fin);
          check_field("time_now", oldest.now, out_now);
          check_field("all_idle", 16'(oldest.all_idle), 16'(out_all_idle));
          check_field("last", 16'(oldest.last), 16'(out_last));
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // sender nearly always offers, receiver mostly stalls
    send_idle_pct = 6;
    recv_stall_pct = 66;
    @(posedge clk);
    push_req(1'b1, 16'h0000, 10'h000);   // tick with nothing to do
    push_req(1'b0, 16'h0000, 10'h000);   // zero service time
    push_req(1'b0, 16'hFFFF, 10'h3FF);
    push_req(1'b0, 16'h5555, 10'h001);
    push_req(1'b0, 16'hAAAA, 10'h2AA);   // tie between queues, lowest index wins
    push_req(1'b1, 16'hFFFF, 10'h3FF);   // all servers start
    push_req(1'b0, 16'h1234, 10'h003);   // busy server counts toward queue length
    push_req(1'b1, 16'h0000, 10'h000);   // zero-service job freed, next one starts
    push_req(1'b1, 16'h0F0F, 10'h155);
    push_req(1'b0, 16'h8001, 10'h200);
    push_req(1'b0, 16'h7FFE, 10'h0FF);
    push_req(1'b0, 16'h00FF, 10'h000);
    push_req(1'b1, 16'h0000, 10'h000);
    push_req(1'b1, 16'hFFFF, 10'h3FF);
    push_req(1'b0, 16'hFF00, 10'h1FE);
    push_req(1'b1, 16'h1111, 10'h111);
    hold_go = 1'b1;
    add_mix(60);
    push_ticks(20);
    wait_drain();

    // receiver nearly always ready, sender mostly idle
    send_idle_pct = 66;
    recv_stall_pct = 6;
    @(posedge clk);
    add_mix(20);
    // arrival burst fills every queue, later arrivals are rejected
    for (int i = 0; i < 200; i++) push_req(1'b0, ID_W'($urandom), SVC_W'($urandom_range(2)));
    push_ticks(20);
    for (int i = 0; i < 10; i++) push_req(1'b0, ID_W'($urandom), SVC_W'($urandom_range(2)));
    push_ticks(60);
    wait_drain();

    // no idling
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    add_mix(50);
    push_ticks(10);
    wait_drain();

    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) errors++;
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
rtl/sqd_pkg.sv
rtl/sqd_ram.sv
rtl/sqd_datapath.sv
rtl/sqd_ctrl.sv
rtl/shortest_queue_dispatch_servers.sv
verif/tb_shortest_queue_dispatch_servers.sv
